>>> rtl/core/alrd_pkg.sv
package alrd_pkg;

    // Window and sample geometry.
    localparam int WINDOW_LENGTH = 20;
    localparam int SAMPLE_BITS   = 10;

    // Fixed field widths.
    localparam int LIGHT_W  = 10;
    localparam int THRESH_W = 10;
    localparam int LEVEL_W  = 8;
    localparam int AVG_W    = 10;
    localparam int PCT_W    = 7;

    localparam logic [THRESH_W-1:0] THRESHOLD_RESET = THRESH_W'(200);
    localparam logic [LEVEL_W-1:0]  LEVEL_MAX       = LEVEL_W'(255);
    localparam int                  PERCENT_SCALE   = 100;
    localparam int                  PCT_PROD_W      = LEVEL_W + $clog2(PERCENT_SCALE + 1);

    // Ring pointer and running total sizing.
    localparam int PTR_W     = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
    localparam int TOTAL_MAX = WINDOW_LENGTH * ((1 << SAMPLE_BITS) - 1);
    localparam int TOTAL_W   = $clog2(TOTAL_MAX + 1);

    // Division of the total by the window length is a multiply by a rounded-up
    // reciprocal. With total * WINDOW_LENGTH < 2**RECIP_SHIFT the quotient is exact.
    localparam int RECIP_SHIFT = TOTAL_W + $clog2(WINDOW_LENGTH);
    localparam int RECIP_MULT  = ((1 << RECIP_SHIFT) + WINDOW_LENGTH - 1) / WINDOW_LENGTH;
    localparam int RECIP_W     = $clog2(RECIP_MULT + 1);

    // Words in flight from input to output register.
    localparam int PIPE_DEPTH = 4;
    localparam int FLIGHT_W   = $clog2(PIPE_DEPTH + 1);

    typedef struct packed {
        logic                   valid;
        logic [SAMPLE_BITS-1:0] average;
    } t_avg_word;

endpackage

>>> rtl/core/alrd_if.sv
interface alrd_in_if;
    logic                         valid;
    logic                         ready;
    logic                         take_sample;
    logic [alrd_pkg::LIGHT_W-1:0] light_sample;

    modport source(output valid, output take_sample, output light_sample, input ready);
    modport sink(input valid, input take_sample, input light_sample, output ready);
endinterface

interface alrd_out_if;
    logic                         valid;
    logic                         ready;
    logic [alrd_pkg::LEVEL_W-1:0] pwm_level;
    logic [alrd_pkg::AVG_W-1:0]   light_average;
    logic [alrd_pkg::PCT_W-1:0]   brightness_percent;

    modport source(output valid, output pwm_level, output light_average,
                   output brightness_percent, input ready);
    modport sink(input valid, input pwm_level, input light_average,
                 input brightness_percent, output ready);
endinterface

>>> rtl/core/alrd_window_avg.sv
module alrd_window_avg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    alrd_in_if.sink             i_in,
    input  logic                i_avg_ready,
    output alrd_pkg::t_avg_word o_avg
);

    logic [alrd_pkg::SAMPLE_BITS-1:0] r_ring [alrd_pkg::WINDOW_LENGTH];
    logic [alrd_pkg::PTR_W-1:0]       r_pos;
    logic [alrd_pkg::TOTAL_W-1:0]     r_total;
    logic                             r_s1_valid;
    logic                             r_s2_valid;
    logic [alrd_pkg::SAMPLE_BITS-1:0] r_s2_avg;

    logic                                           s1_ready;
    logic                                           s2_ready;
    logic                                           accept;
    logic                                           s1_move;
    logic [alrd_pkg::SAMPLE_BITS-1:0]               n_sample;
    logic [alrd_pkg::PTR_W-1:0]                     n_pos;
    logic [alrd_pkg::TOTAL_W-1:0]                   n_total;
    logic [alrd_pkg::TOTAL_W+alrd_pkg::RECIP_W-1:0] quot_prod;
    logic [alrd_pkg::SAMPLE_BITS-1:0]               n_avg;

    assign s2_ready   = !r_s2_valid || i_avg_ready;
    assign s1_ready   = !r_s1_valid || s2_ready;
    assign accept     = i_in.valid && s1_ready;
    assign s1_move    = r_s1_valid && s2_ready;
    assign i_in.ready = s1_ready;

    // The new sample replaces the oldest entry and the total follows.
    assign n_sample = alrd_pkg::SAMPLE_BITS'(i_in.light_sample);
    assign n_total  = r_total - alrd_pkg::TOTAL_W'(r_ring[r_pos])
                              + alrd_pkg::TOTAL_W'(n_sample);
    assign n_pos    = (r_pos == alrd_pkg::PTR_W'(alrd_pkg::WINDOW_LENGTH - 1)) ?
                      '0 : r_pos + 1'b1;

    assign quot_prod = (alrd_pkg::TOTAL_W + alrd_pkg::RECIP_W)'(r_total)
                     * (alrd_pkg::TOTAL_W + alrd_pkg::RECIP_W)'(alrd_pkg::RECIP_MULT);
    assign n_avg     = alrd_pkg::SAMPLE_BITS'(quot_prod >> alrd_pkg::RECIP_SHIFT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < alrd_pkg::WINDOW_LENGTH; i++) begin
                r_ring[i] <= '0;
            end
            r_pos      <= '0;
            r_total    <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (accept && i_in.take_sample) begin
                r_ring[r_pos] <= n_sample;
                r_total       <= n_total;
                r_pos         <= n_pos;
            end
            if (s1_ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_s2_avg <= n_avg;
        end
    end

    assign o_avg.valid   = r_s2_valid;
    assign o_avg.average = r_s2_avg;

endmodule

>>> rtl/core/averaged_light_ramp_dimmer.sv
// Averaged light ramp dimmer. Each input word is one control step; when
// take_sample is set, light_sample enters a 20-entry boxcar moving average
// (ring plus running total, cleared by reset in flip-flops, so no clearing
// pass is needed). Every step compares the average with the low-light
// threshold and ramps the 8-bit lamp level up by one below it and down by one
// above it, saturating at 0 and 255, and holds it at equality. One result
// word per input word carries the level, the average and the level as a
// truncated percentage. The block takes one word per clock cycle while the
// output is not stalled, also under back-to-back traffic; a word passes four
// pipeline registers (input stage, division stage, ramp stage and output
// register) and leaves from the output register. The rate is set by the
// two recurrences: the running-total update at the input stage and the lamp
// level update in the ramp stage. Write the threshold only while no word is
// in flight.
module averaged_light_ramp_dimmer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [alrd_pkg::THRESH_W-1:0] i_cfg_wr_data,
    alrd_in_if.sink                       i_in,
    alrd_out_if.source                    o_out
);

    alrd_pkg::t_avg_word avg_word;

    logic [alrd_pkg::THRESH_W-1:0]    r_threshold;
    logic                             r_l_valid;
    logic [alrd_pkg::LEVEL_W-1:0]     r_lamp;
    logic [alrd_pkg::SAMPLE_BITS-1:0] r_l_avg;
    logic                             r_o_valid;
    logic [alrd_pkg::LEVEL_W-1:0]     r_o_pwm;
    logic [alrd_pkg::AVG_W-1:0]       r_o_avg;
    logic [alrd_pkg::PCT_W-1:0]       r_o_pct;

    logic                              o_ready;
    logic                              l_ready;
    logic                              l_move;
    logic                              avg_move;
    logic [alrd_pkg::LEVEL_W-1:0]      n_lamp;
    logic [alrd_pkg::PCT_PROD_W-1:0]   pct_prod;
    logic [alrd_pkg::PCT_PROD_W:0]     pct_sum;
    logic [alrd_pkg::PCT_W-1:0]        n_pct;

    // The first two stages: sample window, running total and the division
    // of the total by the window length.
    alrd_window_avg u_window_avg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_avg_ready (l_ready),
        .o_avg       (avg_word)
    );

    // Each stage advances when it is empty or when the stage after it moves.
    assign o_ready  = !r_o_valid || o_out.ready;
    assign l_ready  = !r_l_valid || o_ready;
    assign avg_move = avg_word.valid && l_ready;
    assign l_move   = r_l_valid && o_ready;

    // Ramp stage. The threshold is zero-extended so the comparison sees the
    // full quotient, not the masked output field.
    always_comb begin
        n_lamp = r_lamp;
        if ((alrd_pkg::THRESH_W + alrd_pkg::SAMPLE_BITS)'(avg_word.average)
                < (alrd_pkg::THRESH_W + alrd_pkg::SAMPLE_BITS)'(r_threshold)) begin
            if (r_lamp != alrd_pkg::LEVEL_MAX) begin
                n_lamp = r_lamp + 1'b1;
            end
        end else if ((alrd_pkg::THRESH_W + alrd_pkg::SAMPLE_BITS)'(avg_word.average)
                > (alrd_pkg::THRESH_W + alrd_pkg::SAMPLE_BITS)'(r_threshold)) begin
            if (r_lamp != '0) begin
                n_lamp = r_lamp - 1'b1;
            end
        end
    end

    // Percentage: level * 100 / 255, with the division by 255 done as
    // (y + (y >> 8) + 1) >> 8, exact for y up to 65534 (here y <= 25500).
    assign pct_prod = alrd_pkg::PCT_PROD_W'(r_lamp)
                    * alrd_pkg::PCT_PROD_W'(alrd_pkg::PERCENT_SCALE);
    assign pct_sum  = (alrd_pkg::PCT_PROD_W + 1)'(pct_prod)
                    + (alrd_pkg::PCT_PROD_W + 1)'(pct_prod >> alrd_pkg::LEVEL_W)
                    + (alrd_pkg::PCT_PROD_W + 1)'(1);
    assign n_pct    = alrd_pkg::PCT_W'(pct_sum >> alrd_pkg::LEVEL_W);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= alrd_pkg::THRESHOLD_RESET;
            r_lamp      <= '0;
            r_l_valid   <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_threshold <= i_cfg_wr_data;
            end
            if (avg_move) begin
                r_lamp <= n_lamp;
            end
            if (l_ready) begin
                r_l_valid <= avg_word.valid;
            end
            if (o_ready) begin
                r_o_valid <= r_l_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (avg_move) begin
            r_l_avg <= avg_word.average;
        end
        if (l_move) begin
            r_o_pwm <= r_lamp;
            r_o_avg <= alrd_pkg::AVG_W'(r_l_avg);
            r_o_pct <= n_pct;
        end
    end

    assign o_out.valid              = r_o_valid;
    assign o_out.pwm_level          = r_o_pwm;
    assign o_out.light_average      = r_o_avg;
    assign o_out.brightness_percent = r_o_pct;

endmodule

>>> rtl/core/alrd_checker.sv
module alrd_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic [alrd_pkg::LEVEL_W-1:0] i_pwm_level
);

    logic [alrd_pkg::FLIGHT_W-1:0] r_in_flight;
    logic                          r_seen;
    logic [alrd_pkg::LEVEL_W-1:0]  r_last_pwm;
    logic                          in_acc;
    logic                          out_acc;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_flight <= '0;
            r_seen      <= 1'b0;
        end else begin
            if (in_acc && !out_acc) begin
                r_in_flight <= r_in_flight + 1'b1;
            end else if (out_acc && !in_acc) begin
                r_in_flight <= r_in_flight - 1'b1;
            end
            if (out_acc) begin
                r_seen <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_acc) begin
            r_last_pwm <= i_pwm_level;
        end
    end

    // A result word is only delivered for a word that went in.
    a_no_invented_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> (r_in_flight != '0 || in_acc))
        else $error("result word delivered with no word in flight");

    // The pipeline never holds more words than it has stages.
    a_flight_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_flight <= alrd_pkg::FLIGHT_W'(alrd_pkg::PIPE_DEPTH))
        else $error("more words in flight than pipeline stages");

    // The lamp level moves by at most one between consecutive result words.
    a_ramp_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && r_seen) |->
            (i_pwm_level == r_last_pwm || i_pwm_level == r_last_pwm + 1'b1
             || i_pwm_level == r_last_pwm - 1'b1))
        else $error("lamp level jumped by more than one step");

    // A stalled result word stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result word withdrawn while stalled");

endmodule

bind averaged_light_ramp_dimmer alrd_checker u_alrd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_pwm_level (o_out.pwm_level)
);

>>> tb/sv/averaged_light_ramp_dimmer_test.sv
module averaged_light_ramp_dimmer_test;
    timeunit 1ns;
    timeprecision 1ps;

    // One control step as offered on the input channel.
    typedef struct packed {
        logic                         take;
        logic [alrd_pkg::LIGHT_W-1:0] sample;
    } t_light_step;

    // One result word as it should leave the output channel.
    typedef struct packed {
        logic [alrd_pkg::LEVEL_W-1:0] pwm_level;
        logic [alrd_pkg::AVG_W-1:0]   light_average;
        logic [alrd_pkg::PCT_W-1:0]   brightness_percent;
    } t_lamp_result;

    localparam int IDLE_PERCENT   = 13;
    localparam int HOLD_OFF_LEN   = 300;
    localparam int SETTLE_CYCLES  = 8;
    localparam int RESET_CYCLES   = 8;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic [alrd_pkg::THRESH_W-1:0] cfg_wr_data = '0;

    alrd_in_if  in_bus ();
    alrd_out_if out_bus ();

    averaged_light_ramp_dimmer u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in          (in_bus),
        .o_out         (out_bus)
    );

    always #10 clk = ~clk;

    // Every input of the block starts at a known value.
    initial begin
        in_bus.valid        = 1'b0;
        in_bus.take_sample  = 1'b0;
        in_bus.light_sample = '0;
        out_bus.ready       = 1'b0;
    end

    // Shared stimulus state. The queue of pending steps is filled by the
    // sequencing block below and drained by the input driver.
    t_light_step  pending_steps[$];
    t_lamp_result lamp_results_due[$];
    int           error_count = 0;

    // Both sides look at this to switch random idling off for a stretch.
    logic quiet_mode = 1'b0;
    // The sequencing block arms one long receiver hold-off; the ready
    // process runs it and reports back when it is over.
    logic hold_off_armed = 1'b0;
    logic hold_off_done = 1'b0;
    int   hold_off_left = 0;

    // Predictor state: a copy of the boxcar window, the lamp ramp and the
    // threshold register, all at the block's reset values.
    logic [alrd_pkg::SAMPLE_BITS-1:0] window_ring[alrd_pkg::WINDOW_LENGTH];
    int                               window_pos = 0;
    int                               window_total = 0;
    logic [alrd_pkg::AVG_W-1:0]       held_avg = '0;
    logic [alrd_pkg::LEVEL_W-1:0]     lamp = '0;
    logic [alrd_pkg::THRESH_W-1:0]    model_threshold = alrd_pkg::THRESHOLD_RESET;

    initial begin
        foreach (window_ring[i]) window_ring[i] = '0;
    end

    // Advances the predictor by one control step and returns the word the
    // block must produce for it. A step that carries a sample first swaps
    // the oldest window entry for the new one and recomputes the truncated
    // average; every step then ramps the lamp one level toward the side the
    // threshold compare calls for or holds it at equality, clamped to 8 bits.
    function automatic t_lamp_result advance_dimmer(input t_light_step step);
        t_lamp_result res;
        if (step.take) begin
            window_total = window_total - int'(window_ring[window_pos]) + int'(step.sample);
            window_ring[window_pos] = step.sample;
            window_pos = (window_pos == alrd_pkg::WINDOW_LENGTH - 1) ? 0 : window_pos + 1;
            held_avg = alrd_pkg::AVG_W'(window_total / alrd_pkg::WINDOW_LENGTH);
        end
        if (held_avg < model_threshold) begin
            if (lamp != alrd_pkg::LEVEL_MAX) lamp = lamp + 1'b1;
        end else if (held_avg > model_threshold) begin
            if (lamp != '0) lamp = lamp - 1'b1;
        end
        res.pwm_level          = lamp;
        res.light_average      = held_avg;
        res.brightness_percent = alrd_pkg::PCT_W'((int'(lamp) * alrd_pkg::PERCENT_SCALE)
                                                  / int'(alrd_pkg::LEVEL_MAX));
        return res;
    endfunction

    // Input driver. The word on the bus is taken at an edge where valid and
    // ready are both high; the predictor runs at that moment. Once the bus is
    // free, the next pending step goes out unless this cycle is an idle one.
    logic        offering = 1'b0;
    t_light_step offered_step;

    always @(posedge clk) begin
        if (!rst_n) begin
            in_bus.valid <= 1'b0;
            offering = 1'b0;
        end else begin
            if (offering && in_bus.ready) begin
                lamp_results_due.push_back(advance_dimmer(offered_step));
                offering = 1'b0;
            end
            if (!offering) begin
                if (pending_steps.size() != 0 &&
                    (quiet_mode || $urandom_range(99) >= IDLE_PERCENT)) begin
                    offered_step = pending_steps.pop_front();
                    in_bus.valid        <= 1'b1;
                    in_bus.take_sample  <= offered_step.take;
                    in_bus.light_sample <= offered_step.sample;
                    offering = 1'b1;
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver ready. Random stalls, none in quiet mode, and once a long
    // hold-off that lets the pipeline fill and push back on the input.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_bus.ready <= 1'b0;
        end else if (hold_off_left > 0) begin
            hold_off_left = hold_off_left - 1;
            if (hold_off_left == 0) hold_off_done = 1'b1;
            out_bus.ready <= 1'b0;
        end else if (hold_off_armed && !hold_off_done) begin
            hold_off_left = HOLD_OFF_LEN;
            out_bus.ready <= 1'b0;
        end else begin
            out_bus.ready <= quiet_mode || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Output monitor. Every word taken from the block is matched against the
    // oldest prediction, field by field.
    always @(posedge clk) begin
        t_lamp_result want;
        if (rst_n && out_bus.valid && out_bus.ready) begin
            if (lamp_results_due.size() == 0) begin
                $display("%0t: unexpected word pwm=%0d avg=%0d pct=%0d", $time,
                         out_bus.pwm_level, out_bus.light_average,
                         out_bus.brightness_percent);
                error_count = error_count + 1;
            end else begin
                want = lamp_results_due.pop_front();
                if (out_bus.pwm_level !== want.pwm_level) begin
                    $display("%0t: pwm_level expected %0d actual %0d", $time,
                             want.pwm_level, out_bus.pwm_level);
                    error_count = error_count + 1;
                end
                if (out_bus.light_average !== want.light_average) begin
                    $display("%0t: light_average expected %0d actual %0d", $time,
                             want.light_average, out_bus.light_average);
                    error_count = error_count + 1;
                end
                if (out_bus.brightness_percent !== want.brightness_percent) begin
                    $display("%0t: brightness_percent expected %0d actual %0d", $time,
                             want.brightness_percent, out_bus.brightness_percent);
                    error_count = error_count + 1;
                end
            end
        end
    end

    function automatic t_light_step make_step(input logic take, input int value);
        t_light_step step;
        step.take   = take;
        step.sample = alrd_pkg::LIGHT_W'(value);
        return step;
    endfunction

    // Random steps for one threshold setting. Most come as runs, each at least
    // a window long, of one repeated sample near the threshold (some steps
    // carry none), so that the average settles just below, on or just above
    // the threshold and the hold case at equality gets exercised. The rest are
    // single random samples, range extremes and steps without a sample.
    task automatic queue_random_steps(input logic [alrd_pkg::THRESH_W-1:0] thr,
                                      input int count);
        int added;
        int pick;
        int run_len;
        int level;
        added = 0;
        while (added < count) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                level = int'(thr) + int'($urandom_range(6)) - 3;
                if (level < 0) level = 0;
                if (level > 1023) level = 1023;
                run_len = $urandom_range(alrd_pkg::WINDOW_LENGTH + 6, alrd_pkg::WINDOW_LENGTH);
                repeat (run_len) begin
                    if ($urandom_range(9) == 0)
                        pending_steps.push_back(make_step(1'b0, $urandom_range(1023)));
                    else
                        pending_steps.push_back(make_step(1'b1, level));
                    added = added + 1;
                end
            end else if (pick < 72) begin
                pending_steps.push_back(make_step(1'b1, $urandom_range(1023)));
                added = added + 1;
            end else if (pick < 84) begin
                pending_steps.push_back(make_step(1'b1, $urandom_range(1) ? 1023 : 0));
                added = added + 1;
            end else begin
                pending_steps.push_back(make_step(1'b0, $urandom_range(1023)));
                added = added + 1;
            end
        end
    endtask

    // Waits until every step went in and every word came out, then gives
    // the pipeline the settle time to show any stray word.
    task automatic wait_drained();
        while (pending_steps.size() != 0 || offering || lamp_results_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One phase: write the threshold while the block is idle, then run
    // random traffic against it until everything has drained.
    task automatic run_phase(input logic [alrd_pkg::THRESH_W-1:0] thr, input int count,
                             input logic calm, input logic squeeze);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= thr;
        @(posedge clk);
        cfg_wr_en  <= 1'b0;
        quiet_mode <= calm;
        if (squeeze) hold_off_armed <= 1'b1;
        @(negedge clk);
        model_threshold = thr;
        queue_random_steps(thr, count);
        wait_drained();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed steps at the reset threshold. Steps without a sample must
        // leave the average alone while the lamp still ramps; the ignored
        // sample field carries all ones once to show it has no effect.
        pending_steps.push_back(make_step(1'b0, 0));
        pending_steps.push_back(make_step(1'b0, 1023));
        // Smallest and largest sample values.
        pending_steps.push_back(make_step(1'b1, 0));
        pending_steps.push_back(make_step(1'b1, 1023));
        // Enough full-scale samples to wrap the ring past its last entry, so
        // the first overwrite removes the earlier sample from the total.
        repeat (alrd_pkg::WINDOW_LENGTH + 1) pending_steps.push_back(make_step(1'b1, 1023));
        wait_drained();

        // Top threshold with no idling: the lamp climbs into its upper clamp.
        run_phase(10'd1023, 300, 1'b1, 1'b0);
        // Zero threshold with a long receiver hold-off: the lamp falls into
        // its lower clamp while the input sees back-pressure.
        run_phase(10'd0, 300, 1'b0, 1'b1);
        run_phase(alrd_pkg::THRESH_W'($urandom_range(1023)), 250, 1'b0, 1'b0);
        run_phase(10'd512, 250, 1'b0, 1'b0);
        run_phase(10'd1, 200, 1'b0, 1'b0);
        run_phase(10'd1022, 200, 1'b0, 1'b0);
        run_phase(alrd_pkg::THRESH_W'($urandom_range(1023)), 100, 1'b0, 1'b0);

        if (error_count == 0 && lamp_results_due.size() == 0) begin
            $display("averaged_light_ramp_dimmer_test: PASS");
        end else begin
            $display("averaged_light_ramp_dimmer_test: FAIL");
        end
        $finish;
    end

    // Safety net far beyond the slowest correct run.
    initial begin
        #5ms;
        $display("%0t: timeout", $time);
        $display("averaged_light_ramp_dimmer_test: FAIL");
        $finish;
    end

endmodule
